### rtl/core/indirect_block_map_walker_core_defines.svh
// Assertion macros for the checker of the indirect block map walker.
`ifndef INDIRECT_BLOCK_MAP_WALKER_CORE_DEFINES_SVH
`define INDIRECT_BLOCK_MAP_WALKER_CORE_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define IBMW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define IBMW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/ibmw_pkg.sv
// Package with constants, codes, types and functions of the indirect block map walker.
package ibmw_pkg;

  localparam int DIRECT_COUNT   = 12;
  localparam int ROOT_COUNT     = DIRECT_COUNT + 3;
  localparam int ROOT_IDX_W     = $clog2(ROOT_COUNT);
  localparam int IDX_W          = 14;
  localparam int WORD_W         = 32;
  localparam int LOG_BS_W       = 3;
  localparam logic [LOG_BS_W-1:0] MAX_LOG_BS = 3'd6;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_MAP  = 2'd1;
  localparam logic [1:0] REQ_DATA = 2'd2;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  localparam logic [1:0] STAT_MAPPED = 2'd0;
  localparam logic [1:0] STAT_HOLE   = 2'd1;
  localparam logic [1:0] STAT_BEYOND = 2'd2;

  localparam logic [2:0] CLS_DIRECT = 3'd0;
  localparam logic [2:0] CLS_SINGLE = 3'd1;
  localparam logic [2:0] CLS_DOUBLE = 3'd2;
  localparam logic [2:0] CLS_TRIPLE = 3'd3;
  localparam logic [2:0] CLS_BEYOND = 3'd4;

  localparam logic [1:0] RES_MAP  = 2'd0;
  localparam logic [1:0] RES_FIN  = 2'd1;
  localparam logic [1:0] RES_READ = 2'd2;

  typedef struct packed {
    logic       root_we;
    logic       pend_we;
    logic       res_we;
    logic [1:0] res_sel;
    logic       use_mid;
  } ibmw_cmd_t;

  typedef struct packed {
    logic [2:0] map_class;
    logic       root_zero;
    logic       word_zero;
  } ibmw_stat_t;

  // Upper bound (exclusive) of the logical blocks covered up to a given level,
  // saturated to 33 bits so that every 32-bit block number can be compared.
  function automatic logic [WORD_W:0] ibmw_limit(input logic [LOG_BS_W-1:0] lg,
                                                 input logic [1:0] lvl);
    logic [63:0] acc;
    logic [5:0]  sh;
    sh  = 6'd8 + 6'(lg);
    acc = 64'(DIRECT_COUNT);
    if (lvl >= 2'd1) acc = acc + (64'd1 << sh);
    if (lvl >= 2'd2) acc = acc + (64'd1 << (sh + sh));
    if (lvl >= 2'd3) acc = acc + (64'd1 << (sh + sh + sh));
    if (acc > 64'h1_FFFF_FFFF) acc = 64'h1_FFFF_FFFF;
    return acc[WORD_W:0];
  endfunction

endpackage

### rtl/core/ibmw_if.sv
// Valid/ready channel interfaces for the request and result items of the walker.
interface ibmw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [3:0]  slot;
  logic [31:0] data_word;
  logic [31:0] file_block;

  modport source (output valid, req_type, slot, data_word, file_block, input ready);
  modport sink (input valid, req_type, slot, data_word, file_block, output ready);
endinterface

interface ibmw_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [31:0] read_block;
  logic [13:0] read_index;
  logic [31:0] physical_block;
  logic [1:0]  status;

  modport source (output valid, out_kind, read_block, read_index, physical_block, status,
                  input ready);
  modport sink (input valid, out_kind, read_block, read_index, physical_block, status,
                output ready);
endinterface

### rtl/core/ibmw_datapath.sv
// Datapath of the walker: root pointers, block size, range decode, indices and result register.
module ibmw_datapath
  import ibmw_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [LOG_BS_W-1:0] cfg_data,
  input  logic [3:0]          slot,
  input  logic [WORD_W-1:0]   data_word,
  input  logic [WORD_W-1:0]   file_block,
  input  ibmw_cmd_t           cmd,
  output ibmw_stat_t          stat,
  output logic                out_kind,
  output logic [WORD_W-1:0]   read_block,
  output logic [IDX_W-1:0]    read_index,
  output logic [WORD_W-1:0]   physical_block,
  output logic [1:0]          status
);

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] rblk;
    logic [IDX_W-1:0]  ridx;
    logic [WORD_W-1:0] phys;
    logic [1:0]        stat;
  } res_t;

  logic [WORD_W-1:0]   root_ptr_r [ROOT_COUNT];
  logic [LOG_BS_W-1:0] log_bs_r;
  logic [IDX_W-1:0]    pend_mid_r;
  logic [IDX_W-1:0]    pend_low_r;
  res_t                res_r;
  res_t                res_nxt;
  res_t                map_res;

  logic [LOG_BS_W-1:0] lg;
  logic [3:0]          s;
  logic [WORD_W:0]     lim0, lim1, lim2, lim3, lb_ext;
  logic [2:0]          cls;
  logic [WORD_W-1:0]   base, r, r_sh1, r_sh2, root;
  logic [ROOT_IDX_W-1:0] root_idx;
  logic [IDX_W-1:0]    mask, idx;

  assign lg     = (log_bs_r > MAX_LOG_BS) ? MAX_LOG_BS : log_bs_r;
  assign s      = 4'd8 + 4'(lg);
  assign lim0   = ibmw_limit(lg, 2'd0);
  assign lim1   = ibmw_limit(lg, 2'd1);
  assign lim2   = ibmw_limit(lg, 2'd2);
  assign lim3   = ibmw_limit(lg, 2'd3);
  assign lb_ext = {1'b0, file_block};

  always_comb begin
    if (lb_ext < lim0) cls = CLS_DIRECT;
    else if (lb_ext < lim1) cls = CLS_SINGLE;
    else if (lb_ext < lim2) cls = CLS_DOUBLE;
    else if (lb_ext < lim3) cls = CLS_TRIPLE;
    else cls = CLS_BEYOND;
  end

  always_comb begin
    unique case (cls)
      CLS_DIRECT: begin
        base     = '0;
        root_idx = file_block[ROOT_IDX_W-1:0];
      end
      CLS_SINGLE: begin
        base     = lim0[WORD_W-1:0];
        root_idx = ROOT_IDX_W'(DIRECT_COUNT);
      end
      CLS_DOUBLE: begin
        base     = lim1[WORD_W-1:0];
        root_idx = ROOT_IDX_W'(DIRECT_COUNT + 1);
      end
      CLS_TRIPLE: begin
        base     = lim2[WORD_W-1:0];
        root_idx = ROOT_IDX_W'(DIRECT_COUNT + 2);
      end
      default: begin
        base     = '0;
        root_idx = ROOT_IDX_W'(DIRECT_COUNT);
      end
    endcase
  end

  assign root  = root_ptr_r[root_idx];
  assign r     = file_block - base;
  assign r_sh1 = r >> s;
  assign r_sh2 = r >> {s, 1'b0};
  assign mask  = IDX_W'((15'd1 << s) - 15'd1);

  always_comb begin
    unique case (cls)
      CLS_SINGLE: idx = r[IDX_W-1:0];
      CLS_DOUBLE: idx = r_sh1[IDX_W-1:0];
      default:    idx = r_sh2[IDX_W-1:0];
    endcase
  end

  always_comb begin
    map_res = '0;
    unique case (cls) inside
      CLS_DIRECT: begin
        map_res.kind = KIND_FINAL;
        map_res.phys = root;
        map_res.stat = (root == '0) ? STAT_HOLE : STAT_MAPPED;
      end
      CLS_SINGLE, CLS_DOUBLE, CLS_TRIPLE: begin
        if (root == '0) begin
          map_res.kind = KIND_FINAL;
          map_res.stat = STAT_HOLE;
        end else begin
          map_res.kind = KIND_READ;
          map_res.rblk = root;
          map_res.ridx = idx;
        end
      end
      default: begin
        map_res.kind = KIND_FINAL;
        map_res.stat = STAT_BEYOND;
      end
    endcase
  end

  always_comb begin
    res_nxt = '0;
    unique case (cmd.res_sel)
      RES_MAP: res_nxt = map_res;
      RES_FIN: begin
        res_nxt.kind = KIND_FINAL;
        res_nxt.phys = data_word;
        res_nxt.stat = (data_word == '0) ? STAT_HOLE : STAT_MAPPED;
      end
      RES_READ: begin
        res_nxt.kind = KIND_READ;
        res_nxt.rblk = data_word;
        res_nxt.ridx = cmd.use_mid ? pend_mid_r : pend_low_r;
      end
      default: res_nxt = map_res;
    endcase
  end

  assign stat.map_class = cls;
  assign stat.root_zero = (root == '0);
  assign stat.word_zero = (data_word == '0);

  always_ff @(posedge clk) begin
    if (cmd.root_we && (5'(slot) < 5'(ROOT_COUNT))) begin
      root_ptr_r[slot] <= data_word;
    end
    if (cmd.res_we) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_bs_r   <= '0;
      pend_mid_r <= '0;
      pend_low_r <= '0;
    end else begin
      if (cfg_we) begin
        log_bs_r <= cfg_data;
      end
      if (cmd.pend_we && (cls == CLS_DOUBLE)) begin
        pend_low_r <= r[IDX_W-1:0] & mask;
      end
      if (cmd.pend_we && (cls == CLS_TRIPLE)) begin
        pend_mid_r <= r_sh1[IDX_W-1:0] & mask;
        pend_low_r <= r[IDX_W-1:0] & mask;
      end
    end
  end

  assign out_kind       = res_r.kind;
  assign read_block     = res_r.rblk;
  assign read_index     = res_r.ridx;
  assign physical_block = res_r.phys;
  assign status         = res_r.stat;

endmodule

### rtl/core/ibmw_ctrl.sv
// Controller of the walker: walk level state machine, request decode and output handshake.
module ibmw_ctrl
  import ibmw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] req_type,
  input  logic       out_ready,
  input  ibmw_stat_t stat,
  output logic       in_ready,
  output logic       out_valid,
  output ibmw_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LVL1 = 2'd1;
  localparam logic [1:0] S_LVL2 = 2'd2;
  localparam logic [1:0] S_LVL3 = 2'd3;

  logic [1:0] st_r, st_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       acc;

  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;

  always_comb begin
    cmd    = '0;
    st_nxt = st_r;
    if (acc) begin
      unique case (req_type)
        REQ_LOAD: cmd.root_we = 1'b1;
        REQ_MAP: begin
          if (st_r == S_IDLE) begin
            cmd.res_we  = 1'b1;
            cmd.pend_we = 1'b1;
            cmd.res_sel = RES_MAP;
            if (!stat.root_zero) begin
              unique case (stat.map_class)
                CLS_SINGLE: st_nxt = S_LVL1;
                CLS_DOUBLE: st_nxt = S_LVL2;
                CLS_TRIPLE: st_nxt = S_LVL3;
                default:    st_nxt = S_IDLE;
              endcase
            end
          end
        end
        REQ_DATA: begin
          if (st_r != S_IDLE) begin
            cmd.res_we = 1'b1;
            if (stat.word_zero || (st_r == S_LVL1)) begin
              cmd.res_sel = RES_FIN;
              st_nxt      = S_IDLE;
            end else begin
              cmd.res_sel = RES_READ;
              cmd.use_mid = (st_r == S_LVL3);
              st_nxt      = (st_r == S_LVL3) ? S_LVL2 : S_LVL1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_nxt = cmd.res_we ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/core/indirect_block_map_walker_core.sv
// Every item is decoded in its accepting cycle; its result, if any, is valid in the next cycle.
// One item is accepted per cycle while the result register is empty or being drained.
// A walk takes one map item plus at most one data item per pointer level, each giving one result.
// The single output register sets the rate; a stalled result holds further items back.
// Synchronous active-low reset idles the walk, clears the output valid and resets the block
// size to zero; root pointers keep their contents until loaded.
module indirect_block_map_walker_core
  import ibmw_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  ibmw_in_if.sink             in_ch,
  ibmw_out_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [LOG_BS_W-1:0] cfg_data
);

  ibmw_cmd_t  cmd;
  ibmw_stat_t stat;

  ibmw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .req_type  (in_ch.req_type),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  ibmw_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .slot           (in_ch.slot),
    .data_word      (in_ch.data_word),
    .file_block     (in_ch.file_block),
    .cmd            (cmd),
    .stat           (stat),
    .out_kind       (out_ch.out_kind),
    .read_block     (out_ch.read_block),
    .read_index     (out_ch.read_index),
    .physical_block (out_ch.physical_block),
    .status         (out_ch.status)
  );

endmodule

### rtl/core/ibmw_checker.sv
// Port-level assertions for the walker and the bind that attaches them to the top level.
`include "indirect_block_map_walker_core_defines.svh"

module ibmw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [31:0] read_block,
  input logic [13:0] read_index,
  input logic [31:0] physical_block,
  input logic [1:0]  status
);

  `IBMW_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result item dropped while stalled")
  `IBMW_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(read_block) && $stable(read_index) && $stable(physical_block) && $stable(status) && $stable(out_kind), "stalled result item changed")
  `IBMW_ASSERT_ALWAYS(a_ready_empty, !out_valid |-> in_ready, "input stalled with an empty result register")
  `IBMW_ASSERT(a_read_clean, out_valid && !out_kind |-> physical_block == 32'd0 && status == 2'd0, "read request carries final fields")
  `IBMW_ASSERT(a_final_clean, out_valid && out_kind |-> read_block == 32'd0 && read_index == 14'd0 && status != 2'd3, "final result carries read fields")

endmodule

bind indirect_block_map_walker_core ibmw_checker u_ibmw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_kind       (out_ch.out_kind),
  .read_block     (out_ch.read_block),
  .read_index     (out_ch.read_index),
  .physical_block (out_ch.physical_block),
  .status         (out_ch.status)
);
